// ===== rtl/kec_pkg.sv =====
// Shared types and constants for the keyed entry cache.
// No dependencies.
package kec_pkg;

    localparam int KEY_W    = 31;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 16;
    localparam int TMO_W    = 16;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int OCC_W    = 5;

    localparam logic [TMO_W-1:0] DEFAULT_TIMEOUT = 16'd300;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 3'd0,
        KIND_UPDATE  = 3'd1,
        KIND_ADD_UPD = 3'd2,
        KIND_GET     = 3'd3,
        KIND_REMOVE  = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_INVALID = 3'd1,
        ST_EXISTS  = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_EXPIRED = 3'd4
    } t_status;

    // compare unit results
    typedef struct packed {
        logic key_eq;
        logic older;
        logic expired;
    } t_cmp_res;

endpackage

// ===== rtl/kec_ram.sv =====
// Entry storage: one write port, one registered read port.
// Depends on nothing.
module kec_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 143
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/kec_cmp.sv =====
// Shared compare unit: key match, oldest-time compare, lifetime check.
// Depends on kec_pkg.
module kec_cmp (
    input  logic [kec_pkg::KEY_W-1:0]  i_ent_key,
    input  logic [kec_pkg::KEY_W-1:0]  i_req_key,
    input  logic [kec_pkg::TIME_W-1:0] i_ent_time,
    input  logic [kec_pkg::TIME_W-1:0] i_best_time,
    input  logic [kec_pkg::TIME_W-1:0] i_hit_time,
    input  logic [kec_pkg::TMO_W-1:0]  i_timeout,
    input  logic [kec_pkg::TIME_W-1:0] i_now,
    output kec_pkg::t_cmp_res          o_res
);

    logic [kec_pkg::TIME_W:0] w_limit;

    // limit computed one bit wider so it never wraps
    assign w_limit = {1'b0, i_hit_time} + (kec_pkg::TIME_W+1)'(i_timeout);

    always_comb begin
        o_res.key_eq  = (i_ent_key == i_req_key);
        o_res.older   = (i_ent_time < i_best_time);
        o_res.expired = (w_limit < {1'b0, i_now});
    end

endmodule

// ===== rtl/keyed_entry_cache_with_ttl.sv =====
// Each request scans every slot through the single read port of the entry memory,
// one slot per cycle, then passes the drain, decide and output states; key zero or
// an unknown kind goes straight to the decide state. A new request is taken only in
// the idle state, once the previous result has moved into the output register.
// A pending result may wait in the output register while the next request is taken.
// Reset: all slots invalid, occupancy 0, timeout 300; no clearing pass.
module keyed_entry_cache_with_ttl #(
    parameter int ENTRIES    = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kec_pkg::TMO_W-1:0]     i_cfg_data,
    // request
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kec_pkg::KIND_W-1:0]    i_kind,
    input  logic [kec_pkg::KEY_W-1:0]     i_key,
    input  logic [63:0]                   i_write_data,
    input  logic [kec_pkg::LEN_W-1:0]     i_write_length,
    input  logic [kec_pkg::TIME_W-1:0]    i_now_time,
    // result
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [kec_pkg::STATUS_W-1:0]  o_status,
    output logic [63:0]                   o_read_data,
    output logic [kec_pkg::LEN_W-1:0]     o_read_length,
    output logic [kec_pkg::SLOT_W-1:0]    o_slot,
    output logic [kec_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = kec_pkg::KEY_W + kec_pkg::TIME_W + kec_pkg::LEN_W + DATA_WIDTH;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_OUT
    } t_state;

    t_state r_state;

    // request
    logic [kec_pkg::KIND_W-1:0] r_kind;
    logic [kec_pkg::KEY_W-1:0]  r_key;
    logic [DATA_WIDTH-1:0]      r_wdata;
    logic [kec_pkg::LEN_W-1:0]  r_wlen;
    logic [kec_pkg::TIME_W-1:0] r_now;
    logic [kec_pkg::TMO_W-1:0]  r_timeout;

    // table state
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]      r_count;

    // scan
    logic [AW-1:0] r_addr;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;

    logic                       r_hit;
    logic [AW-1:0]              r_hit_idx;
    logic [kec_pkg::TIME_W-1:0] r_hit_time;
    logic [DATA_WIDTH-1:0]      r_hit_data;
    logic [kec_pkg::LEN_W-1:0]  r_hit_len;
    logic                       r_free;
    logic [AW-1:0]              r_free_idx;
    logic [AW-1:0]              r_best_idx;
    logic [kec_pkg::TIME_W-1:0] r_best_time;

    // result staging and output
    kec_pkg::t_status           r_res_status;
    logic [DATA_WIDTH-1:0]      r_res_data;
    logic [kec_pkg::LEN_W-1:0]  r_res_len;
    logic [AW-1:0]              r_res_slot;

    logic                       r_o_valid;
    kec_pkg::t_status           r_o_status;
    logic [63:0]                r_o_data;
    logic [kec_pkg::LEN_W-1:0]  r_o_len;
    logic [kec_pkg::SLOT_W-1:0] r_o_slot;
    logic [kec_pkg::OCC_W-1:0]  r_o_occ;

    // memory
    logic [EW-1:0]              w_rd_data;
    logic [kec_pkg::KEY_W-1:0]  w_ent_key;
    logic [kec_pkg::TIME_W-1:0] w_ent_time;
    logic [kec_pkg::LEN_W-1:0]  w_ent_len;
    logic [DATA_WIDTH-1:0]      w_ent_data;
    kec_pkg::t_cmp_res          w_cmp;

    // decision
    logic             n_wr;
    logic [AW-1:0]    n_idx;
    logic             n_set_valid;
    logic             n_clr_valid;
    logic             n_inc;
    logic             n_dec;
    kec_pkg::t_status n_status;
    logic             n_rd;
    logic [AW-1:0]    w_ins_idx;

    logic w_accept;
    logic w_bypass;

    assign w_accept    = i_valid && o_ready;
    assign w_bypass    = (i_kind > kec_pkg::KIND_REMOVE) || (i_key == '0);
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign {w_ent_key, w_ent_time, w_ent_len, w_ent_data} = w_rd_data;

    kec_ram #(
        .DEPTH(ENTRIES),
        .WIDTH(EW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  ((r_state == S_DECIDE) && n_wr),
        .i_wr_addr(n_idx),
        .i_wr_data({r_key, r_now, r_wlen, r_wdata}),
        .i_rd_en  (r_state == S_SCAN),
        .i_rd_addr(r_addr),
        .o_rd_data(w_rd_data)
    );

    kec_cmp u_cmp (
        .i_ent_key  (w_ent_key),
        .i_req_key  (r_key),
        .i_ent_time (w_ent_time),
        .i_best_time(r_best_time),
        .i_hit_time (r_hit_time),
        .i_timeout  (r_timeout),
        .i_now      (r_now),
        .o_res      (w_cmp)
    );

    assign w_ins_idx = r_free ? r_free_idx : r_best_idx;

    always_comb begin
        n_wr        = 1'b0;
        n_idx       = r_hit_idx;
        n_set_valid = 1'b0;
        n_clr_valid = 1'b0;
        n_inc       = 1'b0;
        n_dec       = 1'b0;
        n_status    = kec_pkg::ST_DONE;
        n_rd        = 1'b0;
        if (r_kind > kec_pkg::KIND_REMOVE) begin
            n_idx = '0;
        end else if (r_key == '0) begin
            n_idx    = '0;
            n_status = kec_pkg::ST_INVALID;
        end else begin
            unique case (r_kind)
                kec_pkg::KIND_ADD: begin
                    if (r_hit) begin
                        n_status = kec_pkg::ST_EXISTS;
                    end else begin
                        n_idx       = w_ins_idx;
                        n_wr        = 1'b1;
                        n_set_valid = 1'b1;
                        n_inc       = r_free;
                    end
                end
                kec_pkg::KIND_UPDATE: begin
                    if (r_hit) begin
                        n_wr = 1'b1;
                    end else begin
                        n_idx    = '0;
                        n_status = kec_pkg::ST_ABSENT;
                    end
                end
                kec_pkg::KIND_ADD_UPD: begin
                    n_wr        = 1'b1;
                    n_set_valid = 1'b1;
                    if (!r_hit) begin
                        n_idx = w_ins_idx;
                        n_inc = r_free;
                    end
                end
                kec_pkg::KIND_GET: begin
                    if (!r_hit) begin
                        n_idx    = '0;
                        n_status = kec_pkg::ST_ABSENT;
                    end else if (w_cmp.expired) begin
                        n_clr_valid = 1'b1;
                        n_dec       = 1'b1;
                        n_status    = kec_pkg::ST_EXPIRED;
                    end else begin
                        n_rd = 1'b1;
                    end
                end
                default: begin
                    if (r_hit) begin
                        n_clr_valid = 1'b1;
                        n_dec       = 1'b1;
                    end else begin
                        n_idx    = '0;
                        n_status = kec_pkg::ST_ABSENT;
                    end
                end
            endcase
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= kec_pkg::DEFAULT_TIMEOUT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= (i_cfg_data == '0) ? kec_pkg::DEFAULT_TIMEOUT : i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_wdata <= i_write_data[DATA_WIDTH-1:0];
            r_wlen  <= i_write_length;
            r_now   <= i_now_time;
        end
    end

    // valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (r_state == S_DECIDE) begin
            if (n_set_valid) begin
                r_valid[n_idx] <= 1'b1;
            end
            if (n_clr_valid) begin
                r_valid[n_idx] <= 1'b0;
            end
            if (n_inc) begin
                r_count <= r_count + CW'(1);
            end else if (n_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // scan tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == S_SCAN);
            r_cmp_idx <= r_addr;
            if (w_accept) begin
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                r_best_idx <= '0;
            end else if (r_cmp_vld) begin
                if (r_valid[r_cmp_idx] && w_cmp.key_eq && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_cmp_idx;
                    r_hit_time <= w_ent_time;
                    r_hit_data <= w_ent_data;
                    r_hit_len  <= w_ent_len;
                end
                if (!r_valid[r_cmp_idx] && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
                if ((r_cmp_idx == '0) || w_cmp.older) begin
                    r_best_idx  <= r_cmp_idx;
                    r_best_time <= w_ent_time;
                end
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_addr  <= '0;
                        r_state <= w_bypass ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_res_status <= n_status;
                    r_res_slot   <= n_idx;
                    r_res_data   <= n_rd ? r_hit_data : '0;
                    r_res_len    <= n_rd ? r_hit_len : '0;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_data   <= 64'(r_res_data);
                        r_o_len    <= r_res_len;
                        r_o_slot   <= kec_pkg::SLOT_W'(r_res_slot);
                        r_o_occ    <= kec_pkg::OCC_W'(r_count);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_read_data   = r_o_data;
    assign o_read_length = r_o_len;
    assign o_slot        = r_o_slot;
    assign o_occupancy   = r_o_occ;

endmodule
